>>> rtl/core/shd_pkg.sv
// ============================================================================
// shd_pkg
// shared types, controller commands and the fixed prefix code table
// ============================================================================
package shd_pkg;

    typedef struct packed {
        logic [10:0] bits;
        logic [3:0]  len;
    } t_code_entry;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic step_ok;
        logic flush_ok;
    } t_stat;

    typedef struct packed {
        logic       hit;
        logic [7:0] index;
    } t_match;

    localparam int TABLE_SIZE = 256;

    localparam t_code_entry CODE_TAB [TABLE_SIZE] = '{
        '{11'h002,4'd2},'{11'h01b,4'd5},'{11'h048,4'd7},'{11'h06c,4'd7},
        '{11'h0a1,4'd8},'{11'h011,4'd8},'{11'h010,4'd7},'{11'h03f,4'd6},
        '{11'h015,4'd5},'{11'h034,4'd7},'{11'h069,4'd7},'{11'h00b,4'd7},
        '{11'h013,4'd7},'{11'h02d,4'd6},'{11'h039,4'd8},'{11'h0ac,4'd9},
        '{11'h025,4'd7},'{11'h058,4'd9},'{11'h1f0,4'd9},'{11'h1f8,4'd9},
        '{11'h1dd,4'd10},'{11'h3f3,4'd10},'{11'h22b,4'd10},'{11'h323,4'd10},
        '{11'h0f4,4'd9},'{11'h18d,4'd10},'{11'h0ab,4'd10},'{11'h363,4'd10},
        '{11'h1eb,4'd10},'{11'h043,4'd8},'{11'h04f,4'd9},'{11'h0d4,4'd8},
        '{11'h037,4'd6},'{11'h0d3,4'd10},'{11'h044,4'd9},'{11'h2cd,4'd10},
        '{11'h3c5,4'd10},'{11'h3f9,4'd10},'{11'h30d,4'd10},'{11'h3cd,4'd10},
        '{11'h094,4'd9},'{11'h1ac,4'd10},'{11'h033,4'd10},'{11'h014,4'd10},
        '{11'h271,4'd10},'{11'h2f0,4'd10},'{11'h1f4,4'd9},'{11'h078,4'd8},
        '{11'h027,4'd7},'{11'h0c3,4'd8},'{11'h0ef,4'd8},'{11'h197,4'd9},
        '{11'h053,4'd8},'{11'h0b1,4'd8},'{11'h00d,4'd9},'{11'h161,4'd9},
        '{11'h007,4'd9},'{11'h0f1,4'd9},'{11'h199,4'd9},'{11'h191,4'd10},
        '{11'h123,4'd10},'{11'h0bc,4'd9},'{11'h144,4'd9},'{11'h1f3,4'd10},
        '{11'h0cf,4'd8},'{11'h050,4'd7},'{11'h07c,4'd7},'{11'h004,4'd7},
        '{11'h021,4'd8},'{11'h051,4'd8},'{11'h080,4'd9},'{11'h070,4'd9},
        '{11'h13d,4'd9},'{11'h063,4'd10},'{11'h2d7,4'd10},'{11'h371,4'd10},
        '{11'h19d,4'd9},'{11'h2ab,4'd10},'{11'h1c7,4'd10},'{11'h333,4'd10},
        '{11'h12c,4'd9},'{11'h09d,4'd10},'{11'h16b,4'd10},'{11'h36b,4'd10},
        '{11'h1d3,4'd10},'{11'h171,4'd10},'{11'h1e3,4'd10},'{11'h233,4'd10},
        '{11'h0d7,4'd10},'{11'h2cb,4'd10},'{11'h170,4'd9},'{11'h0a8,4'd9},
        '{11'h0c7,4'd9},'{11'h105,4'd9},'{11'h0eb,4'd9},'{11'h0d8,4'd8},
        '{11'h0f3,4'd9},'{11'h03c,4'd8},'{11'h1ab,4'd9},'{11'h18f,4'd9},
        '{11'h097,4'd9},'{11'h030,4'd7},'{11'h041,4'd8},'{11'h14f,4'd9},
        '{11'h01c,4'd6},'{11'h028,4'd8},'{11'h0bd,4'd9},'{11'h0c4,4'd9},
        '{11'h098,4'd8},'{11'h08f,4'd9},'{11'h00c,4'd8},'{11'h0b3,4'd8},
        '{11'h085,4'd8},'{11'h08c,4'd8},'{11'h047,4'd8},'{11'h079,4'd8},
        '{11'h059,4'd7},'{11'h040,4'd7},'{11'h017,4'd8},'{11'h019,4'd8},
        '{11'h04b,4'd8},'{11'h0e1,4'd8},'{11'h0a3,4'd8},'{11'h073,4'd8},
        '{11'h06f,4'd8},'{11'h068,4'd7},'{11'h008,4'd7},'{11'h065,4'd7},
        '{11'h01f,4'd6},'{11'h029,4'd7},'{11'h04c,4'd7},'{11'h07d,4'd7},
        '{11'h00f,4'd8},'{11'h083,4'd8},'{11'h001,4'd8},'{11'h087,4'd8},
        '{11'h067,4'd8},'{11'h0e7,4'd8},'{11'h057,4'd8},'{11'h074,4'd8},
        '{11'h1cb,4'd9},'{11'h1c4,4'd9},'{11'h081,4'd9},'{11'h04d,4'd9},
        '{11'h131,4'd9},'{11'h163,4'd10},'{11'h180,4'd9},'{11'h3d7,4'd10},
        '{11'h02b,4'd10},'{11'h145,4'd10},'{11'h06b,4'd10},'{11'h03d,4'd10},
        '{11'h32b,4'd10},'{11'h0f9,4'd10},'{11'h0e3,4'd10},'{11'h245,4'd10},
        '{11'h12b,4'd10},'{11'h031,4'd10},'{11'h3eb,4'd10},'{11'h1b9,4'd10},
        '{11'h114,4'd9},'{11'h1f9,4'd10},'{11'h133,4'd10},'{11'h02c,4'd10},
        '{11'h2dd,4'd10},'{11'h1c1,4'd10},'{11'h31d,4'd10},'{11'h1d1,4'd10},
        '{11'h138,4'd9},'{11'h061,4'd10},'{11'h2e3,4'd10},'{11'h345,4'd10},
        '{11'h26b,4'd10},'{11'h0cd,4'd10},'{11'h0cb,4'd10},'{11'h14d,4'd10},
        '{11'h038,4'd9},'{11'h3c1,4'd10},'{11'h23d,4'd10},'{11'h3bc,4'd10},
        '{11'h0c5,4'd10},'{11'h3ac,4'd10},'{11'h3e3,4'd10},'{11'h299,4'd10},
        '{11'h3d3,4'd10},'{11'h214,4'd10},'{11'h203,4'd10},'{11'h1bc,4'd10},
        '{11'h29d,4'd10},'{11'h381,4'd10},'{11'h263,4'd10},'{11'h08d,4'd10},
        '{11'h054,4'd8},'{11'h103,4'd9},'{11'h05d,4'd8},'{11'h020,4'd6},
        '{11'h009,4'd7},'{11'h3c7,4'd10},'{11'h307,4'd10},'{11'h0b8,4'd8},
        '{11'h1f1,4'd9},'{11'h22c,4'd10},'{11'h045,4'd10},'{11'h003,4'd10},
        '{11'h11d,4'd10},'{11'h1c5,4'd10},'{11'h34d,4'd10},'{11'h01d,4'd10},
        '{11'h000,4'd9},'{11'h3b9,4'd10},'{11'h0dd,4'd10},'{11'h181,4'd10},
        '{11'h10d,4'd10},'{11'h0b9,4'd10},'{11'h1cd,4'd10},'{11'h394,4'd10},
        '{11'h1bd,4'd10},'{11'h194,4'd10},'{11'h38d,4'd10},'{11'h158,4'd10},
        '{11'h3bd,4'd10},'{11'h0c1,4'd10},'{11'h3dd,4'd10},'{11'h0f8,4'd10},
        '{11'h0d1,4'd9},'{11'h091,4'd9},'{11'h099,4'd10},'{11'h2f8,4'd10},
        '{11'h023,4'd10},'{11'h071,4'd10},'{11'h2d3,4'd10},'{11'h391,4'd10},
        '{11'h049,4'd7},'{11'h231,4'd10},'{11'h107,4'd10},'{11'h261,4'd10},
        '{11'h223,4'd10},'{11'h018,4'd8},'{11'h205,4'd10},'{11'h2c1,4'd10},
        '{11'h1d7,4'd10},'{11'h0f0,4'd10},'{11'h2c5,4'd10},'{11'h300,4'd10},
        '{11'h3d1,4'd10},'{11'h3a8,4'd10},'{11'h21d,4'd10},'{11'h500,4'd11},
        '{11'h005,4'd10},'{11'h358,4'd10},'{11'h2f9,4'd10},'{11'h1a8,4'd10},
        '{11'h2b9,4'd10},'{11'h28d,4'd10},'{11'h02f,4'd7},'{11'h024,4'd6}
    };

    // lowest matching index among the first limit entries
    function automatic t_match lookup(input logic [15:0] code, input logic [4:0] len,
                                      input int unsigned limit);
        t_match m;
        m = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if ((i < limit) && ({5'd0, CODE_TAB[i].bits} == code)
                    && ({1'b0, CODE_TAB[i].len} == len)) begin
                m.hit   = 1'b1;
                m.index = 8'(i);
            end
        end
        return m;
    endfunction

endpackage

>>> rtl/core/shd_ctrl.sv
// ============================================================================
// shd_ctrl
// sequencer: load byte, step a bit a cycle unless stalled, flush held symbol
// ============================================================================
module shd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  shd_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output shd_pkg::t_cmd  o_cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BITS  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_BITS;
                end
            end
            S_BITS: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_FLUSH;
                end else if (i_stat.step_ok) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> rtl/core/shd_datapath.sv
// ============================================================================
// shd_datapath
// bit shifter, partial code, table match, held symbol and output register
// ============================================================================
module shd_datapath #(
    parameter int MAX_CODE_BITS = 11,
    parameter int SYMBOL_COUNT  = 256,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  shd_pkg::t_cmd  i_cmd,
    output shd_pkg::t_stat o_stat,
    input  logic [7:0]     i_data_byte,
    input  logic [3:0]     i_valid_bits,
    input  logic           i_new_message,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_symbol,
    output logic           o_invalid_code,
    output logic           o_last
);
    localparam int LW  = $clog2(MAX_CODE_BITS + 2);
    localparam int CIW = $clog2(MAX_CODE_BITS);
    localparam int NW  = $clog2(BITS_PER_ITEM + 1);

    logic [BITS_PER_ITEM-1:0] r_data;
    logic [NW-1:0]            r_cnt;
    logic [MAX_CODE_BITS-1:0] r_code, n_code;
    logic [LW-1:0]            r_len, n_len;
    logic                     r_pv, r_pinv;
    logic [7:0]               r_psym;
    logic                     r_ov;
    logic                     over, hit, out_busy, out_load;
    logic [NW-1:0]            nb;
    shd_pkg::t_match          m;

    // bit added at the next higher position, dropped when length overflows
    always_comb begin
        n_code = r_code;
        if (r_len < LW'(MAX_CODE_BITS)) begin
            n_code[r_len[CIW-1:0]] = r_data[0];
        end
        n_len = r_len + LW'(1);
    end

    assign m        = shd_pkg::lookup(16'(n_code), 5'(n_len), SYMBOL_COUNT);
    assign over     = n_len > LW'(MAX_CODE_BITS);
    assign hit      = over || ((n_len >= LW'(2)) && m.hit);
    assign out_busy = r_ov && !i_out_ready;
    assign nb       = (i_valid_bits > 4'(BITS_PER_ITEM)) ? NW'(BITS_PER_ITEM)
                                                         : NW'(i_valid_bits);

    // held symbol moves into the output register
    assign out_load = r_pv && ((i_cmd.step && hit) || i_cmd.flush);

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.step_ok  = !(hit && r_pv && out_busy);
    assign o_stat.flush_ok = !(r_pv && out_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_len  <= '0;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.load) begin
                r_data <= i_data_byte[BITS_PER_ITEM-1:0];
                r_cnt  <= nb;
                if (i_new_message) begin
                    r_code <= '0;
                    r_len  <= '0;
                end
            end
            if (i_cmd.step) begin
                r_data <= r_data >> 1;
                r_cnt  <= r_cnt - NW'(1);
                if (hit) begin
                    r_code <= '0;
                    r_len  <= '0;
                    r_pv   <= 1'b1;
                    r_pinv <= over;
                    r_psym <= over ? 8'd0 : m.index;
                    if (r_pv) begin
                        o_symbol       <= r_psym;
                        o_invalid_code <= r_pinv;
                        o_last         <= 1'b0;
                    end
                end else begin
                    r_code <= n_code;
                    r_len  <= n_len;
                end
            end
            if (i_cmd.flush && r_pv) begin
                r_pv           <= 1'b0;
                o_symbol       <= r_psym;
                o_invalid_code <= r_pinv;
                o_last         <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_ov;
endmodule

>>> rtl/core/static_huffman_decoder_top.sv
// ============================================================================
// static_huffman_decoder_top
// static prefix code decoder, stream bits read least significant first
// ============================================================================
// usage:
//   input channel (i_in_valid / o_in_ready) carries one compressed byte per
//   beat with its count of stream bits and a new-message flag
//   output channel (o_out_valid / i_out_ready) carries one decoded symbol per
//   beat, with invalid_code for a code of too many bits and last on the final
//   symbol caused by an input byte
// timing:
//   one stream bit is matched per cycle against the code table unless a
//   stall holds the bit steps; a byte passes through load, its bit steps,
//   an end check and a flush, and a new byte is taken only back in idle
//   a found symbol is held so that last can be marked; it leaves on the
//   next found symbol or at the end of the byte
// reset:
//   synchronous active low; clears the partial code and drops any beat held
// stall:
//   the output register keeps its beat while i_out_ready is low; bit steps go
//   on until a second symbol would need the output register
// ============================================================================
module static_huffman_decoder_top #(
    parameter int MAX_CODE_BITS = 11,
    parameter int SYMBOL_COUNT  = 256,
    parameter int BITS_PER_ITEM = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic [3:0] i_valid_bits,
    input  logic       i_new_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_symbol,
    output logic       o_invalid_code,
    output logic       o_last
);
    shd_pkg::t_cmd  cmd;
    shd_pkg::t_stat stat;

    // sequencer
    shd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // shifter, matcher and output register
    shd_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOL_COUNT  (SYMBOL_COUNT),
        .BITS_PER_ITEM (BITS_PER_ITEM)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_data_byte    (i_data_byte),
        .i_valid_bits   (i_valid_bits),
        .i_new_message  (i_new_message),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_invalid_code (o_invalid_code),
        .o_last         (o_last)
    );
endmodule

>>> rtl/core/shd_checker.sv
// ============================================================================
// shd_checker
// port level checks of the decoder
// ============================================================================
module shd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_symbol,
    input logic       o_invalid_code,
    input logic       o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_symbol)
            && $stable(o_invalid_code) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_inval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid_code |-> o_symbol == 8'd0)
        else $error("invalid code with nonzero symbol");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted byte");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left output valid or input not ready");
endmodule

bind static_huffman_decoder_top shd_checker u_shd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_symbol       (o_symbol),
    .o_invalid_code (o_invalid_code),
    .o_last         (o_last)
);

>>> verif/tb_static_huffman_decoder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_static_huffman_decoder_top
// checks the prefix code decoder against a bit-serial prediction of its
// output symbols, under several phases of input idling and output stalls
// ============================================================================
module tb_static_huffman_decoder_top;

    localparam int MAX_CODE_BITS = 11;
    localparam int BITS_PER_ITEM = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [7:0] data_byte;
        logic [3:0] valid_bits;
        logic       new_message;
    } t_byte_beat;

    typedef struct {
        logic [7:0] symbol;
        logic       invalid_code;
        logic       last;
    } t_symbol_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic [3:0] i_valid_bits;
    logic       i_new_message;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_symbol;
    logic       o_invalid_code;
    logic       o_last;

    static_huffman_decoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_valid_bits   (i_valid_bits),
        .i_new_message  (i_new_message),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_invalid_code (o_invalid_code),
        .o_last         (o_last)
    );

    // pending bytes and predicted symbols
    t_byte_beat   byte_queue[$];
    t_symbol_beat symbol_queue[$];

    // predictor copy of the partial code
    logic [10:0] pred_code;
    logic [4:0]  pred_len;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatch_count;
    int  watchdog;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // search the code table, lowest index wins on equal codes
    function automatic int find_code(logic [10:0] code, logic [4:0] len);
        for (int i = 0; i < shd_pkg::TABLE_SIZE; i++) begin
            if (shd_pkg::CODE_TAB[i].bits == code
                    && {1'b0, shd_pkg::CODE_TAB[i].len} == len)
                return i;
        end
        return -1;
    endfunction

    // run one accepted byte through the bit-serial decode and queue its symbols
    task automatic predict_symbols(input t_byte_beat b);
        int nbits;
        int sym;
        int produced;
        t_symbol_beat r;
        produced = 0;
        if (b.new_message) begin
            pred_code = '0;
            pred_len  = '0;
        end
        nbits = (b.valid_bits > BITS_PER_ITEM) ? BITS_PER_ITEM : int'(b.valid_bits);
        for (int i = 0; i < nbits; i++) begin
            // the overflowing bit is not stored
            if (pred_len < MAX_CODE_BITS)
                pred_code[pred_len] = b.data_byte[i];
            pred_len++;
            if (pred_len > MAX_CODE_BITS) begin
                r.symbol = 8'd0;
                r.invalid_code = 1'b1;
                r.last = 1'b0;
                symbol_queue.push_back(r);
                produced++;
                pred_code = '0;
                pred_len  = '0;
            end else if (pred_len >= 2) begin
                sym = find_code(pred_code, pred_len);
                if (sym >= 0) begin
                    r.symbol = 8'(sym);
                    r.invalid_code = 1'b0;
                    r.last = 1'b0;
                    symbol_queue.push_back(r);
                    produced++;
                    pred_code = '0;
                    pred_len  = '0;
                end
            end
        end
        // last marks the final symbol of this byte
        if (produced > 0)
            symbol_queue[symbol_queue.size() - 1].last = 1'b1;
    endtask

    function automatic t_byte_beat make_beat(int d, int n, int nm);
        t_byte_beat b;
        b.data_byte   = 8'(d);
        b.valid_bits  = 4'(n);
        b.new_message = 1'(nm);
        return b;
    endfunction

    // push the bits of one table code, packing them into full bytes
    task automatic push_code_bits(input int idx, inout logic [15:0] acc, inout int acc_len);
        for (int i = 0; i < shd_pkg::CODE_TAB[idx].len; i++) begin
            acc[acc_len] = shd_pkg::CODE_TAB[idx].bits[i];
            acc_len++;
            if (acc_len >= 8) begin
                byte_queue.push_back(make_beat(int'(acc[7:0]), 8, 0));
                acc = acc >> 8;
                acc_len -= 8;
            end
        end
    endtask

    // driver: holds valid and payload until the beat is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_symbols(make_beat(int'(i_data_byte), int'(i_valid_bits),
                                          int'(i_new_message)));
                void'(byte_queue.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // keep holding
            end else if (byte_queue.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid    <= 1'b1;
                i_data_byte   <= byte_queue[0].data_byte;
                i_valid_bits  <= byte_queue[0].valid_bits;
                i_new_message <= byte_queue[0].new_message;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready, random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_symbol_beat exp_beat;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (symbol_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected symbol beat: sym=%0d inv=%0b last=%0b",
                             o_symbol, o_invalid_code, o_last);
            end else begin
                exp_beat = symbol_queue.pop_front();
                if (o_symbol !== exp_beat.symbol || o_invalid_code !== exp_beat.invalid_code
                        || o_last !== exp_beat.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"symbol mismatch: exp sym=%0d inv=%0b last=%0b,",
                                  " got sym=%0d inv=%0b last=%0b"},
                                 exp_beat.symbol, exp_beat.invalid_code, exp_beat.last,
                                 o_symbol, o_invalid_code, o_last);
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [15:0] acc;
        int acc_len;
        int phase_items;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_byte = '0;
        i_valid_bits = '0;
        i_new_message = 1'b0;
        i_out_ready = 1'b0;
        pred_code = '0;
        pred_len = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        watchdog = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of every field and each special case
        byte_queue.push_back(make_beat(8'h02, 2, 1));   // shortest code, symbol 0
        byte_queue.push_back(make_beat(8'h00, 0, 0));   // zero stream bits
        byte_queue.push_back(make_beat(8'hff, 15, 0));  // more bits than a byte holds
        byte_queue.push_back(make_beat(8'haa, 8, 1));
        byte_queue.push_back(make_beat(8'h55, 9, 0));
        byte_queue.push_back(make_beat(8'h01, 1, 1));
        byte_queue.push_back(make_beat(8'h00, 0, 1));   // new message with no bits
        byte_queue.push_back(make_beat(8'h00, 8, 1));   // zeros: nine zero bits match the all-zero code of symbol 208
        byte_queue.push_back(make_beat(8'h00, 8, 0));
        byte_queue.push_back(make_beat(8'h00, 8, 0));
        byte_queue.push_back(make_beat(8'h00, 8, 1));   // 11-bit code 0x500 for symbol 247
        byte_queue.push_back(make_beat(8'h05, 3, 0));
        byte_queue.push_back(make_beat(8'hff, 8, 1));   // ones: six one bits match code 0x03f of symbol 7
        byte_queue.push_back(make_beat(8'hff, 8, 0));
        byte_queue.push_back(make_beat(8'h0a, 4, 0));   // ends a code begun by the ones before it
        byte_queue.push_back(make_beat(8'haa, 8, 1));   // four symbols in one byte
        byte_queue.push_back(make_beat(8'h80, 8, 0));
        byte_queue.push_back(make_beat(8'h7f, 7, 1));

        // random phases: idle patterns change between phases, once traffic drains
        for (int ph = 0; ph < 5; ph++) begin
            acc = '0;
            acc_len = 0;
            phase_items = 0;
            wait (byte_queue.size() == 0 && symbol_queue.size() == 0);
            repeat (20) @(posedge i_clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (phase_items < 22) begin
                if ($urandom_range(9) < 7) begin
                    // well-formed stream of table codes in full bytes
                    push_code_bits(int'($urandom_range(255)), acc, acc_len);
                    phase_items++;
                end else begin
                    // noise byte with random width and message flag
                    byte_queue.push_back(make_beat(int'($urandom_range(255)),
                                                   int'($urandom_range(15)),
                                                   int'($urandom_range(3) == 0)));
                    acc = '0;
                    acc_len = 0;
                    phase_items++;
                end
            end
            if (acc_len > 0)
                byte_queue.push_back(make_beat(int'(acc[7:0]), acc_len, 0));
        end

        wait (byte_queue.size() == 0 && symbol_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && symbol_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/shd_pkg.sv
rtl/core/shd_ctrl.sv
rtl/core/shd_datapath.sv
rtl/core/static_huffman_decoder_top.sv
rtl/core/shd_checker.sv
verif/tb_static_huffman_decoder_top.sv
